>>> hw/rtl/sid_pkg.sv
// ----------------------------------------------------------------------------
// sid_pkg
// Shared widths and controller/datapath handshake types for the signed
// integer divider.
// ----------------------------------------------------------------------------
package sid_pkg;

  // Operand and quotient width
  localparam int DATA_WIDTH = 32;

  // Iteration counter width, one step per quotient bit
  localparam int CNT_W = $clog2(DATA_WIDTH);

  // Commands from controller to datapath
  typedef struct packed {
    logic load;    // capture operands, magnitudes and special-case flag
    logic step;    // one restoring shift-subtract step
    logic finish;  // apply sign, write output register
  } sid_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic special;  // zero divisor or overflow, no iterations needed
  } sid_stat_t;

endpackage

>>> hw/rtl/sid_op_if.sv
// ----------------------------------------------------------------------------
// sid_op_if
// Operand channel: a valid/ready word carrying dividend and divisor.
// ----------------------------------------------------------------------------
interface sid_op_if;
  import sid_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] dividend;
  logic signed [DATA_WIDTH-1:0] divisor;

  modport source (output valid, output dividend, output divisor, input ready);
  modport sink   (input valid, input dividend, input divisor, output ready);

endinterface

>>> hw/rtl/sid_res_if.sv
// ----------------------------------------------------------------------------
// sid_res_if
// Result channel: a valid/ready word carrying quotient and saturated flag.
// ----------------------------------------------------------------------------
interface sid_res_if;
  import sid_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [DATA_WIDTH-1:0] quotient;
  logic                         saturated;

  modport source (output valid, output quotient, output saturated, input ready);
  modport sink   (input valid, input quotient, input saturated, output ready);

endinterface

>>> hw/rtl/sid_ctrl.sv
// ----------------------------------------------------------------------------
// sid_ctrl
// Sequencer for the divider: accepts an operand word, runs one step per
// quotient bit, then hands the result to the output register.
// ----------------------------------------------------------------------------
module sid_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              op_valid,
  output logic              op_ready,
  output logic              res_valid,
  input  logic              res_ready,
  input  sid_pkg::sid_stat_t stat,
  output sid_pkg::sid_cmd_t  cmd
);
  import sid_pkg::*;

  typedef enum logic [1:0] {
    IDLE,
    RUN,
    DONE
  } state_t;

  state_t           state;
  logic [CNT_W-1:0] cnt;
  logic             out_free;

  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(DATA_WIDTH - 1);

  // Output register can take a new word when empty or being drained
  assign out_free = !res_valid || res_ready;
  assign op_ready = (state == IDLE);

  // Command decode
  always_comb begin
    cmd.load   = (state == IDLE) && op_valid;
    cmd.step   = (state == RUN) && !stat.special;
    cmd.finish = (state == DONE) && out_free;
  end

  // State, step counter and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      cnt       <= '0;
      res_valid <= 1'b0;
    end else begin
      // Output valid: set on finish, cleared when the word is taken
      if (state == DONE && out_free) begin
        res_valid <= 1'b1;
      end else if (res_valid && res_ready) begin
        res_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          if (op_valid) begin
            state <= RUN;
            cnt   <= '0;
          end
        end
        RUN: begin
          if (stat.special || cnt == LAST_STEP) begin
            state <= DONE;
          end
          cnt <= cnt + 1'b1;
        end
        DONE: begin
          if (out_free) begin
            state <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/sid_dp.sv
// ----------------------------------------------------------------------------
// sid_dp
// Divider datapath: operand magnitudes, restoring shift-subtract on
// remainder and quotient registers, sign fixup and output register.
// ----------------------------------------------------------------------------
module sid_dp (
  input  logic                                  clk,
  input  sid_pkg::sid_cmd_t                     cmd,
  output sid_pkg::sid_stat_t                    stat,
  input  logic signed [sid_pkg::DATA_WIDTH-1:0] dividend,
  input  logic signed [sid_pkg::DATA_WIDTH-1:0] divisor,
  output logic signed [sid_pkg::DATA_WIDTH-1:0] quotient,
  output logic                                  saturated
);
  import sid_pkg::*;

  localparam logic [DATA_WIDTH-1:0] SIGN_ONLY = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam logic [DATA_WIDTH-1:0] MAX_POS   = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam logic [DATA_WIDTH-1:0] MINUS_ONE = '1;

  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] quo;   // dividend bits shift out, quotient bits in
  logic [DATA_WIDTH-1:0] dmag;
  logic                  neg;
  logic                  special;

  logic [DATA_WIDTH-1:0] a_u;
  logic [DATA_WIDTH-1:0] b_u;
  logic [DATA_WIDTH-1:0] a_mag;
  logic [DATA_WIDTH-1:0] b_mag;
  logic                  is_special;
  logic [DATA_WIDTH:0]   rem_sh;
  logic [DATA_WIDTH:0]   diff;
  logic                  q_bit;
  logic [DATA_WIDTH-1:0] q_signed;

  // Operand magnitudes and special cases
  always_comb begin
    a_u        = dividend;
    b_u        = divisor;
    a_mag      = a_u[DATA_WIDTH-1] ? (~a_u + 1'b1) : a_u;
    b_mag      = b_u[DATA_WIDTH-1] ? (~b_u + 1'b1) : b_u;
    is_special = (b_u == '0) || (a_u == SIGN_ONLY && b_u == MINUS_ONE);
  end

  // One restoring step: shift in next dividend bit, trial subtract
  always_comb begin
    rem_sh = {rem, quo[DATA_WIDTH-1]};
    diff   = rem_sh - {1'b0, dmag};
    q_bit  = !diff[DATA_WIDTH];
  end

  // Sign fixup
  assign q_signed = neg ? (~quo + 1'b1) : quo;

  assign stat.special = special;

  // Working registers and output register
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      rem     <= '0;
      quo     <= a_mag;
      dmag    <= b_mag;
      neg     <= a_u[DATA_WIDTH-1] ^ b_u[DATA_WIDTH-1];
      special <= is_special;
    end else if (cmd.step) begin
      rem <= q_bit ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
      quo <= {quo[DATA_WIDTH-2:0], q_bit};
    end
    if (cmd.finish) begin
      quotient  <= special ? MAX_POS : q_signed;
      saturated <= special;
    end
  end

endmodule

>>> hw/rtl/signed_integer_divider_unit.sv
// ----------------------------------------------------------------------------
// signed_integer_divider_unit
// Signed 32-bit divider, quotient truncated toward zero, with saturation.
// ----------------------------------------------------------------------------
// Usage:
//   operands (sink): valid/ready word with dividend and divisor, both signed.
//   result (source): valid/ready word with quotient and saturated flag.
//   One operand word gives exactly one result word, in order.
//   A zero divisor, or the most negative dividend over minus one, returns
//   the largest positive value with saturated set.
// Sequence:
//   The accepting edge loads the operands, one restoring shift-subtract
//   step per quotient bit follows in a single subtractor, and a sign fixup
//   writes the output register. Saturating cases skip the steps.
//   One division is in flight at a time; operands are taken again as soon
//   as the result is in the output register.
// Reset: rst (synchronous) returns the sequencer to idle and empties the
//   output register. When the receiver stalls the result holds, the next
//   division still runs, then waits until the output register drains.
// ----------------------------------------------------------------------------
module signed_integer_divider_unit (
  input  logic      clk,
  input  logic      rst,
  sid_op_if.sink    operands,
  sid_res_if.source result
);
  import sid_pkg::*;

  sid_cmd_t  cmd;
  sid_stat_t stat;

  // Sequencer
  sid_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .op_valid  (operands.valid),
    .op_ready  (operands.ready),
    .res_valid (result.valid),
    .res_ready (result.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath
  sid_dp u_dp (
    .clk       (clk),
    .cmd       (cmd),
    .stat      (stat),
    .dividend  (operands.dividend),
    .divisor   (operands.divisor),
    .quotient  (result.quotient),
    .saturated (result.saturated)
  );

endmodule

>>> tb/signed_integer_divider_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_integer_divider_unit_tb
// Self-checking bench for the signed divider. A short table of operand
// words covers the extremes and the saturating cases. Random operand words
// follow. Every accepted word gets its expected quotient and flag, either
// typed in the table or computed by a local shift-subtract model, and each
// result word is checked in order. Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module signed_integer_divider_unit_tb;
  import sid_pkg::*;

  typedef logic signed [DATA_WIDTH-1:0] word_t;

  typedef struct packed {
    word_t quotient;
    logic  saturated;
  } quot_word_t;

  typedef struct packed {
    word_t      dividend;
    word_t      divisor;
    logic       typed;     // expected value given in the row
    quot_word_t expected;
  } div_row_t;

  localparam word_t MAX_POS   = {1'b0, {(DATA_WIDTH-1){1'b1}}};
  localparam word_t MIN_NEG   = {1'b1, {(DATA_WIDTH-1){1'b0}}};
  localparam word_t MINUS_ONE = '1;
  localparam word_t ONE       = word_t'(1);
  localparam word_t ZERO      = '0;

  localparam int RANDOM_WORDS  = 1000;
  localparam int IDLE_PCT      = 37;
  localparam int LONG_STALL    = 300;
  localparam int STALL_AFTER   = 400;
  localparam int DRAIN_LATENCY = 40;
  localparam int CYCLE_LIMIT   = 500000;

  localparam int NUM_ROWS = 24;
  localparam div_row_t DIRECTED [NUM_ROWS] = '{
    '{MIN_NEG,   MINUS_ONE, 1'b1, '{MAX_POS, 1'b1}},
    '{ZERO,      ZERO,      1'b1, '{MAX_POS, 1'b1}},
    '{MAX_POS,   ZERO,      1'b1, '{MAX_POS, 1'b1}},
    '{MIN_NEG,   ZERO,      1'b1, '{MAX_POS, 1'b1}},
    '{MINUS_ONE, ZERO,      1'b1, '{MAX_POS, 1'b1}},
    '{MIN_NEG,   ONE,       1'b1, '{MIN_NEG, 1'b0}},
    '{MIN_NEG,   MIN_NEG,   1'b1, '{ONE, 1'b0}},
    '{MAX_POS,   MIN_NEG,   1'b1, '{ZERO, 1'b0}},
    '{MIN_NEG,   MAX_POS,   1'b1, '{MINUS_ONE, 1'b0}},
    '{MAX_POS,   MINUS_ONE, 1'b1, '{MIN_NEG + ONE, 1'b0}},
    '{MAX_POS,   MAX_POS,   1'b1, '{ONE, 1'b0}},
    '{MAX_POS,   ONE,       1'b1, '{MAX_POS, 1'b0}},
    '{MINUS_ONE, MIN_NEG,   1'b1, '{ZERO, 1'b0}},
    '{MINUS_ONE, MINUS_ONE, 1'b1, '{ONE, 1'b0}},
    '{ONE,       MINUS_ONE, 1'b1, '{MINUS_ONE, 1'b0}},
    '{MIN_NEG + ONE, MINUS_ONE, 1'b1, '{MAX_POS, 1'b0}},
    '{MIN_NEG,   word_t'(2),  1'b0, '{ZERO, 1'b0}},
    '{MIN_NEG,   -word_t'(2), 1'b0, '{ZERO, 1'b0}},
    '{word_t'(7),  word_t'(2),  1'b0, '{ZERO, 1'b0}},
    '{-word_t'(7), word_t'(2),  1'b0, '{ZERO, 1'b0}},
    '{word_t'(7),  -word_t'(2), 1'b0, '{ZERO, 1'b0}},
    '{-word_t'(7), -word_t'(2), 1'b0, '{ZERO, 1'b0}},
    '{ZERO,        -word_t'(5), 1'b0, '{ZERO, 1'b0}},
    '{word_t'(5),  word_t'(7),  1'b0, '{ZERO, 1'b0}}
  };

  logic clk = 1'b0;
  logic rst = 1'b1;

  sid_op_if  op_ch ();
  sid_res_if res_ch ();

  signed_integer_divider_unit uut (
    .clk      (clk),
    .rst      (rst),
    .operands (op_ch),
    .result   (res_ch)
  );

  quot_word_t quot_queue[$];
  int         mismatches      = 0;
  int         words_sent      = 0;
  int         words_checked   = 0;
  int         saturated_seen  = 0;
  int         cycle_count     = 0;
  logic       calm            = 1'b0;  // no idling on either side
  logic       long_stall_done = 1'b0;

  always #5 clk = ~clk;

  // Quotient truncated toward zero, magnitudes one bit wider than a word
  function automatic quot_word_t predict_quotient(input word_t a, input word_t b);
    logic [DATA_WIDTH:0] mag_a;
    logic [DATA_WIDTH:0] mag_b;
    logic [DATA_WIDTH:0] rem;
    logic [DATA_WIDTH:0] q;
    quot_word_t          r;
    if (b == ZERO || (a == MIN_NEG && b == MINUS_ONE)) begin
      r.quotient  = MAX_POS;
      r.saturated = 1'b1;
      return r;
    end
    mag_a = a[DATA_WIDTH-1] ? ({1'b0, ~a} + 1'b1) : {1'b0, a};
    mag_b = b[DATA_WIDTH-1] ? ({1'b0, ~b} + 1'b1) : {1'b0, b};
    rem = '0;
    q   = '0;
    for (int i = DATA_WIDTH; i >= 0; i--) begin
      rem = {rem[DATA_WIDTH-1:0], mag_a[i]};
      q   = q << 1;
      if (rem >= mag_b) begin
        rem  = rem - mag_b;
        q[0] = 1'b1;
      end
    end
    r.quotient  = (a[DATA_WIDTH-1] ^ b[DATA_WIDTH-1]) ? -word_t'(q[DATA_WIDTH-1:0])
                                                      : word_t'(q[DATA_WIDTH-1:0]);
    r.saturated = 1'b0;
    return r;
  endfunction

  // Operand mix: full range, small values, powers of two, extremes
  function automatic word_t rand_word();
    word_t w;
    case ($urandom_range(7))
      0, 1, 2: w = word_t'($urandom);
      3: w = word_t'($urandom_range(40)) - word_t'(20);
      4: begin
        w = ONE << $urandom_range(DATA_WIDTH-1);
        if ($urandom_range(1)) w = -w;
      end
      5: begin
        case ($urandom_range(5))
          0: w = MIN_NEG;
          1: w = MAX_POS;
          2: w = ZERO;
          3: w = ONE;
          4: w = MINUS_ONE;
          default: w = MIN_NEG + ONE;
        endcase
      end
      6: begin
        w = word_t'($urandom >> $urandom_range(DATA_WIDTH-1));
        if ($urandom_range(1)) w = -w;
      end
      default: w = word_t'($urandom);
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0d] mismatch: %s", cycle_count, msg);
  endtask

  // Offer one operand word; called and returns at a falling edge
  task automatic send_operands(input word_t a, input word_t b, input logic typed,
                               input quot_word_t typed_exp);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      op_ch.valid <= 1'b0;
      @(negedge clk);
    end
    op_ch.valid    <= 1'b1;
    op_ch.dividend <= a;
    op_ch.divisor  <= b;
    @(posedge clk);
    while (!op_ch.ready) @(posedge clk);
    quot_queue.push_back(typed ? typed_exp : predict_quotient(a, b));
    words_sent++;
    @(negedge clk);
  endtask

  // Hold the operand side off until every pending quotient is out
  task automatic pause_until_drained();
    op_ch.valid <= 1'b0;
    @(negedge clk);
    while (quot_queue.size() != 0) @(negedge clk);
  endtask

  // Result sink: random stalls, one long hold-off once STALL_AFTER words are sent
  initial begin : result_sink
    res_ch.ready = 1'b0;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (!long_stall_done && words_sent >= STALL_AFTER) begin
        res_ch.ready <= 1'b0;
        repeat (LONG_STALL) @(negedge clk);
        long_stall_done = 1'b1;
      end else begin
        res_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
        @(negedge clk);
      end
    end
  end

  // Result checker: each accepted word against the oldest expectation
  always @(posedge clk) begin
    quot_word_t exp_word;
    if (!rst && res_ch.valid && res_ch.ready) begin
      if (quot_queue.size() == 0) begin
        report_mismatch($sformatf("unexpected result word q=%0d sat=%0b",
                                  res_ch.quotient, res_ch.saturated));
      end else begin
        exp_word = quot_queue.pop_front();
        words_checked++;
        if (res_ch.saturated) saturated_seen++;
        if (res_ch.quotient !== exp_word.quotient)
          report_mismatch($sformatf("quotient %0d, expected %0d",
                                    res_ch.quotient, exp_word.quotient));
        if (res_ch.saturated !== exp_word.saturated)
          report_mismatch($sformatf("saturated %0b, expected %0b (quotient %0d)",
                                    res_ch.saturated, exp_word.saturated,
                                    exp_word.quotient));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("watchdog expired with %0d quotients pending", quot_queue.size());
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Stimulus and end of run
  initial begin : operand_source
    word_t      a;
    word_t      b;
    quot_word_t no_exp;
    no_exp         = '0;
    op_ch.valid    = 1'b0;
    op_ch.dividend = '0;
    op_ch.divisor  = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed table
    foreach (DIRECTED[i])
      send_operands(DIRECTED[i].dividend, DIRECTED[i].divisor, DIRECTED[i].typed,
                    DIRECTED[i].expected);

    // Random operand words
    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 300) pause_until_drained();
      if (n == 550) calm = 1'b1;
      if (n == 750) calm = 1'b0;
      case ($urandom_range(19))
        0: begin
          a = rand_word();
          b = ZERO;
        end
        1: begin
          a = MIN_NEG;
          b = MINUS_ONE;
        end
        default: begin
          a = rand_word();
          b = rand_word();
        end
      endcase
      send_operands(a, b, 1'b0, no_exp);
    end
    op_ch.valid <= 1'b0;

    while (quot_queue.size() != 0) @(posedge clk);
    repeat (DRAIN_LATENCY) @(posedge clk);

    $display("%0d operand words sent (%0d from the table), %0d quotients checked",
             words_sent, NUM_ROWS, words_checked);
    $display("%0d saturated results, %0d mismatches", saturated_seen, mismatches);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

>>> sim.f
hw/rtl/sid_pkg.sv
hw/rtl/sid_op_if.sv
hw/rtl/sid_res_if.sv
hw/rtl/sid_ctrl.sv
hw/rtl/sid_dp.sv
hw/rtl/signed_integer_divider_unit.sv
tb/signed_integer_divider_unit_tb.sv
